// File: hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by the front end, the sequencer back end and the top level.
package i2cms_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_SEND_BYTE = 3'd3;
    localparam logic [2:0] OP_WAIT_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_BYTE = 3'd5;
    localparam logic [2:0] OP_SEND_ACK  = 3'd6;
    localparam logic [2:0] OP_SEND_NACK = 3'd7;

    localparam logic [3:0] BIT_LAST            = 4'd7;
    localparam logic [7:0] ACK_TIMEOUT_DEFAULT = 8'd250;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } out_item_t;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } q_item_t;

endpackage

// File: hdl/i2cms_front.sv
// Front end: accepts tick/command transfers, classifies them and queues them.
// Depends on i2cms_pkg.
module i2cms_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2cms_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output i2cms_pkg::q_item_t  q_item
);
    import i2cms_pkg::*;

    q_item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push;
    logic                 pop;
    q_item_t              classified;

    assign s_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        classified.is_cmd         = (s_data.op != OP_TICK);
        classified.op             = s_data.op;
        classified.tx_byte        = s_data.tx_byte;
        classified.ack_after_read = s_data.ack_after_read;
        classified.sda_in         = s_data.sda_in;
    end

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/i2cms_back.sv
// Back end: SCL/SDA step sequencer, one queued item per step, with result register.
// Depends on i2cms_pkg.
module i2cms_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          ack_timeout,
    input  logic                q_valid,
    output logic                q_ready,
    input  i2cms_pkg::q_item_t   q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cms_pkg::out_item_t m_data
);
    import i2cms_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'd0,
        ST_ST0   = 5'd1,
        ST_ST1   = 5'd2,
        ST_ST2   = 5'd3,
        ST_SP0   = 5'd4,
        ST_SP1   = 5'd5,
        ST_SP2   = 5'd6,
        ST_TXA   = 5'd7,
        ST_TXB   = 5'd8,
        ST_WA0   = 5'd9,
        ST_WA1   = 5'd10,
        ST_WAP   = 5'd11,
        ST_WAEND = 5'd12,
        ST_RXH   = 5'd13,
        ST_RXL   = 5'd14,
        ST_AK0   = 5'd15,
        ST_AK1   = 5'd16,
        ST_AK2   = 5'd17,
        ST_AK3   = 5'd18,
        ST_NK0   = 5'd19,
        ST_NK1   = 5'd20,
        ST_NK2   = 5'd21
    } step_t;

    step_t      step_reg, step_next, step_cur;
    logic [2:0] cmd_reg, cmd_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ackc_reg, ackc_next;
    logic [7:0] rx_reg, rx_next;
    logic       tflag_reg, tflag_next;
    logic       was_active;
    logic       out_scl, out_sda;
    logic       advance;
    logic       out_valid_reg;
    out_item_t  out_reg, out_next;

    assign advance = q_valid && (!out_valid_reg || m_ready);
    assign q_ready = advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        step_cur   = step_reg;
        cmd_next   = cmd_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ackc_next  = ackc_reg;
        rx_next    = rx_reg;
        tflag_next = tflag_reg;

        if (step_reg == ST_IDLE && q_item.is_cmd) begin
            cmd_next = q_item.op;
            bit_next = '0;
            unique case (q_item.op)
                OP_START:     step_cur = ST_ST0;
                OP_STOP:      step_cur = ST_SP0;
                OP_SEND_BYTE: begin
                    shift_next = q_item.tx_byte;
                    step_cur   = ST_TXA;
                end
                OP_WAIT_ACK:  begin
                    tflag_next = 1'b0;
                    poll_next  = '0;
                    step_cur   = ST_WA0;
                end
                OP_READ_BYTE: begin
                    ackc_next  = q_item.ack_after_read;
                    shift_next = '0;
                    step_cur   = ST_RXH;
                end
                OP_SEND_ACK:  step_cur = ST_AK0;
                default:      step_cur = ST_NK0;
            endcase
        end
        was_active = (step_cur != ST_IDLE);

        unique case (step_cur)
            ST_ST0:   begin sda_next = 1'b1; scl_next = 1'b1; end
            ST_ST1:   sda_next = 1'b0;
            ST_ST2:   scl_next = 1'b0;
            ST_SP0:   sda_next = 1'b0;
            ST_SP1:   scl_next = 1'b1;
            ST_SP2:   sda_next = 1'b1;
            ST_TXA:   sda_next = shift_next[7];
            ST_TXB:   scl_next = 1'b1;
            ST_WA0:   sda_next = 1'b1;
            ST_WA1:   scl_next = 1'b1;
            ST_WAEND: scl_next = 1'b0;
            ST_RXH:   scl_next = 1'b1;
            ST_RXL:   scl_next = 1'b0;
            ST_AK0:   sda_next = 1'b0;
            ST_AK1:   scl_next = 1'b1;
            ST_AK2:   scl_next = 1'b0;
            ST_AK3:   sda_next = 1'b1;
            ST_NK0:   sda_next = 1'b1;
            ST_NK1:   scl_next = 1'b1;
            ST_NK2:   scl_next = 1'b0;
            default:  ;
        endcase
        out_scl = scl_next;
        out_sda = sda_next;

        unique case (step_cur)
            ST_ST0:  step_next = ST_ST1;
            ST_ST1:  step_next = ST_ST2;
            ST_SP0:  step_next = ST_SP1;
            ST_SP1:  step_next = ST_SP2;
            ST_SP2:  step_next = (cmd_next == OP_WAIT_ACK) ? ST_WAEND : ST_IDLE;
            ST_TXA:  step_next = ST_TXB;
            ST_TXB:  begin
                scl_next = 1'b0;
                if (bit_next >= BIT_LAST) begin
                    sda_next  = 1'b1;
                    step_next = ST_IDLE;
                end else begin
                    bit_next   = bit_next + 1'b1;
                    shift_next = {shift_next[6:0], 1'b0};
                    step_next  = ST_TXA;
                end
            end
            ST_WA0:  step_next = ST_WA1;
            ST_WA1, ST_WAP: begin
                if (!q_item.sda_in) begin
                    step_next = ST_WAEND;
                end else if (poll_next >= ack_timeout) begin
                    tflag_next = 1'b1;
                    step_next  = ST_SP0;
                end else begin
                    poll_next = poll_next + 1'b1;
                    step_next = ST_WAP;
                end
            end
            ST_RXH:  begin
                shift_next = {shift_next[6:0], q_item.sda_in};
                step_next  = ST_RXL;
            end
            ST_RXL:  begin
                if (bit_next >= BIT_LAST) begin
                    rx_next   = shift_next;
                    step_next = ackc_next ? ST_AK0 : ST_NK0;
                end else begin
                    bit_next  = bit_next + 1'b1;
                    step_next = ST_RXH;
                end
            end
            ST_AK0:  step_next = ST_AK1;
            ST_AK1:  step_next = ST_AK2;
            ST_AK2:  step_next = ST_AK3;
            ST_NK0:  step_next = ST_NK1;
            ST_NK1:  step_next = ST_NK2;
            default: step_next = ST_IDLE;
        endcase

        out_next.scl_out   = out_scl;
        out_next.sda_out   = out_sda;
        out_next.busy_res  = (step_next != ST_IDLE);
        out_next.done_res  = was_active && (step_next == ST_IDLE);
        out_next.rx_byte   = rx_next;
        out_next.ack_error = tflag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_IDLE;
            cmd_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            poll_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ackc_reg      <= 1'b0;
            rx_reg        <= '0;
            tflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (advance) begin
                step_reg      <= step_next;
                cmd_reg       <= cmd_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                poll_reg      <= poll_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ackc_reg      <= ackc_next;
                rx_reg        <= rx_next;
                tflag_reg     <= tflag_next;
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: timeout register, front end, back end.
// Depends on i2cms_pkg, i2cms_front and i2cms_back.
//
//   channel   ports                       transfer carries
//   s_        s_valid s_ready s_data      one tick or command (in_item_t)
//   m_        m_valid m_ready m_data      pin levels and status (out_item_t)
//   cfg       cfg_wr_en cfg_wr_data       ack_timeout write, no handshake
//
// One item per cycle sustained while m_ is not stalled; each item passes from s_ to m_
// through the queue register, then the sequencer step into the result register.
// A two-entry queue decouples intake from the result register; m_ stalls
// back up into the queue and then drop s_ready.
// Synchronous active-low reset: idle, pins released, ack_timeout 250.
module i2c_master_bit_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cms_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cms_pkg::out_item_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);
    import i2cms_pkg::*;

    logic [7:0] ack_timeout_reg;
    logic       q_valid;
    logic       q_ready;
    q_item_t    q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= ACK_TIMEOUT_DEFAULT;
        end else if (cfg_wr_en) begin
            ack_timeout_reg <= cfg_wr_data;
        end
    end

    i2cms_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    i2cms_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ack_timeout (ack_timeout_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the I2C master bit sequencer (i2c_master_bit_sequencer).
// Predicts SCL/SDA levels and status per transfer in a scoreboard class; needs i2cms_pkg.
// Drives command sequences with random gaps, stalls and ack_timeout settings.
module testbench;
    import i2cms_pkg::*;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_ST0, SQ_ST1, SQ_ST2, SQ_SP0, SQ_SP1, SQ_SP2, SQ_TXA, SQ_TXB,
        SQ_WA0, SQ_WA1, SQ_WAP, SQ_WAEND, SQ_RXH, SQ_RXL, SQ_AK0, SQ_AK1, SQ_AK2,
        SQ_AK3, SQ_NK0, SQ_NK1, SQ_NK2
    } seq_step_t;

    localparam int NO_ACK = -1;

    class pin_scoreboard;
        out_item_t  expected_pins[$];
        int         errors = 0;
        int         checked = 0;
        int         ack_timeouts = 0;
        logic [7:0] timeout_limit = ACK_TIMEOUT_DEFAULT;
        seq_step_t  step = SQ_IDLE;
        logic [2:0] cmd = OP_TICK;
        logic [3:0] bit_idx = '0;
        logic [7:0] shifter = '0;
        logic [7:0] polls = '0;
        logic       scl = 1'b1;
        logic       sda = 1'b1;
        logic       ack_sel = 1'b0;
        logic [7:0] rx_last = '0;
        logic       timed_out = 1'b0;

        function void set_timeout(logic [7:0] v);
            timeout_limit = v;
        endfunction

        function bit idle();
            return step == SQ_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function seq_step_t poll_decision(logic sda_in);
            if (!sda_in)
                return SQ_WAEND;
            if (polls >= timeout_limit) begin
                timed_out = 1'b1;
                ack_timeouts++;
                return SQ_SP0;
            end
            polls = polls + 8'd1;
            return SQ_WAP;
        endfunction

        function out_item_t step_pins(in_item_t it);
            seq_step_t nxt;
            logic      was_active;
            out_item_t r;
            if (step == SQ_IDLE && it.op != OP_TICK) begin
                cmd = it.op;
                bit_idx = '0;
                case (it.op)
                    OP_START: step = SQ_ST0;
                    OP_STOP: step = SQ_SP0;
                    OP_SEND_BYTE: begin
                        shifter = it.tx_byte;
                        step = SQ_TXA;
                    end
                    OP_WAIT_ACK: begin
                        timed_out = 1'b0;
                        polls = '0;
                        step = SQ_WA0;
                    end
                    OP_READ_BYTE: begin
                        ack_sel = it.ack_after_read;
                        shifter = '0;
                        step = SQ_RXH;
                    end
                    OP_SEND_ACK: step = SQ_AK0;
                    default: step = SQ_NK0;
                endcase
            end
            was_active = (step != SQ_IDLE);

            case (step)
                SQ_ST0: begin
                    sda = 1'b1;
                    scl = 1'b1;
                end
                SQ_ST1, SQ_SP0, SQ_AK0: sda = 1'b0;
                SQ_ST2, SQ_WAEND, SQ_RXL, SQ_AK2, SQ_NK2: scl = 1'b0;
                SQ_SP1, SQ_TXB, SQ_WA1, SQ_RXH, SQ_AK1, SQ_NK1: scl = 1'b1;
                SQ_SP2, SQ_WA0, SQ_AK3, SQ_NK0: sda = 1'b1;
                SQ_TXA: sda = shifter[7];
                default: ;
            endcase
            r.scl_out = scl;
            r.sda_out = sda;

            nxt = SQ_IDLE;
            case (step)
                SQ_ST0: nxt = SQ_ST1;
                SQ_ST1: nxt = SQ_ST2;
                SQ_SP0: nxt = SQ_SP1;
                SQ_SP1: nxt = SQ_SP2;
                SQ_SP2: nxt = (cmd == OP_WAIT_ACK) ? SQ_WAEND : SQ_IDLE;
                SQ_TXA: nxt = SQ_TXB;
                SQ_TXB: begin
                    scl = 1'b0;
                    if (bit_idx >= BIT_LAST) begin
                        sda = 1'b1;
                        nxt = SQ_IDLE;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        shifter = shifter << 1;
                        nxt = SQ_TXA;
                    end
                end
                SQ_WA0: nxt = SQ_WA1;
                SQ_WA1, SQ_WAP: nxt = poll_decision(it.sda_in);
                SQ_RXH: begin
                    shifter = {shifter[6:0], it.sda_in};
                    nxt = SQ_RXL;
                end
                SQ_RXL: begin
                    if (bit_idx >= BIT_LAST) begin
                        rx_last = shifter;
                        nxt = ack_sel ? SQ_AK0 : SQ_NK0;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        nxt = SQ_RXH;
                    end
                end
                SQ_AK0: nxt = SQ_AK1;
                SQ_AK1: nxt = SQ_AK2;
                SQ_AK2: nxt = SQ_AK3;
                SQ_NK0: nxt = SQ_NK1;
                SQ_NK1: nxt = SQ_NK2;
                default: nxt = SQ_IDLE;
            endcase
            step = nxt;

            r.busy_res = (nxt != SQ_IDLE);
            r.done_res = was_active && (nxt == SQ_IDLE);
            r.rx_byte = rx_last;
            r.ack_error = timed_out;
            return r;
        endfunction

        function void note_transfer(in_item_t it);
            expected_pins.push_back(step_pins(it));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                          checked, name, got, want));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_pins.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            want = expected_pins.pop_front();
            compare_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
            compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
            compare_field("rx_byte", got.rx_byte, want.rx_byte);
            compare_field("ack_error", 8'(got.ack_error), 8'(want.ack_error));
            checked++;
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    pin_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int settings_used = 0;

    i2c_master_bit_sequencer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_result(m_data);
    end

    initial begin : result_sink
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = 120;
            end else if (hold == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 11);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(in_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_transfer(it);
        items_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [7:0] v);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_timeout(v);
        settings_used++;
    endtask

    function automatic logic pick_sda(logic [2:0] op, logic [7:0] rx_bits, int ack_at, int k);
        if (op == OP_READ_BYTE && k < 16)
            return rx_bits[3'(7 - k / 2)];
        if (op == OP_WAIT_ACK)
            return (ack_at != NO_ACK && k >= ack_at) ? 1'b0 : 1'b1;
        return 1'($urandom);
    endfunction

    task automatic run_sequence(logic [2:0] op, logic [7:0] txb, logic ackr,
                                logic [7:0] rx_bits, int ack_at, int noise_pct);
        in_item_t it;
        int k;
        it.op = op;
        it.tx_byte = txb;
        it.ack_after_read = ackr;
        it.sda_in = pick_sda(op, rx_bits, ack_at, 0);
        send_item(it);
        k = 1;
        while (!sb.idle()) begin
            it.op = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7)) : OP_TICK;
            it.tx_byte = 8'($urandom);
            it.ack_after_read = 1'($urandom);
            it.sda_in = pick_sda(op, rx_bits, ack_at, k);
            send_item(it);
            k++;
        end
    endtask

    task automatic random_sequence(int limit);
        in_item_t it;
        int ack_at;
        if ($urandom_range(0, 9) == 0) begin
            it = in_item_t'(($bits(in_item_t))'($urandom));
            send_item(it);
        end else begin
            if ($urandom_range(0, 3) == 0)
                ack_at = NO_ACK;
            else if ($urandom_range(0, 1) == 0)
                ack_at = $urandom_range(1, 4);
            else
                ack_at = $urandom_range(1, limit + 2);
            run_sequence(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                         8'($urandom), ack_at, 5);
        end
    endtask

    initial begin : stimulus
        in_item_t it;
        logic [7:0] limit;
        int target;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle ticks, then every command at least once at the reset timeout
        it = '0;
        send_item(it);
        it = '1;
        it.op = OP_TICK;
        send_item(it);
        run_sequence(OP_START, 8'h00, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_SEND_BYTE, 8'hFF, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_WAIT_ACK, 8'h00, 1'b0, 8'h00, 1, 0);
        run_sequence(OP_READ_BYTE, 8'h00, 1'b1, 8'hA5, NO_ACK, 0);
        run_sequence(OP_READ_BYTE, 8'hFF, 1'b0, 8'hFF, NO_ACK, 0);
        run_sequence(OP_SEND_ACK, 8'h00, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_SEND_NACK, 8'h00, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_SEND_BYTE, 8'h00, 1'b1, 8'h00, NO_ACK, 100);
        run_sequence(OP_STOP, 8'h00, 1'b0, 8'h00, NO_ACK, 0);

        // zero timeout: first high poll gives up; one: ack on the last allowed poll
        write_timeout(8'd0);
        run_sequence(OP_WAIT_ACK, 8'h00, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_WAIT_ACK, 8'h00, 1'b0, 8'h00, 1, 0);
        write_timeout(8'd1);
        run_sequence(OP_WAIT_ACK, 8'h00, 1'b0, 8'h00, NO_ACK, 0);
        run_sequence(OP_WAIT_ACK, 8'h00, 1'b0, 8'h00, 2, 0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: limit = 8'd255;
                1: limit = 8'($urandom_range(2, 12));
                2: limit = 8'd1;
                3: limit = 8'd0;
                default: limit = 8'($urandom_range(1, 40));
            endcase
            write_timeout(limit);
            if (p == 1)
                hold_req = 1'b1;
            if (p == 4)
                idle_on = 1'b0;
            target = items_sent + 270;
            while (items_sent < target)
                random_sequence(int'(limit));
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        $display("Ran %0d transfers in, %0d results checked, %0d ack timeouts,",
                 items_sent, sb.checked, sb.ack_timeouts);
        $display("across %0d ack_timeout settings including 0, 1 and 255.", settings_used);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
